>>> rtl/button_auto_repeat_defines.svh
// Assertion macros used by the checker file.
`ifndef BUTTON_AUTO_REPEAT_DEFINES_SVH
`define BUTTON_AUTO_REPEAT_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define BAR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define BAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/bar_pkg.sv
// ----------------------------------------------------------------------------
// bar_pkg
// Types, constants and helpers for the button auto-repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package bar_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned MASK_W    = 32;
    localparam int unsigned APB_W     = 32;
    localparam int unsigned ADDR_W    = 3;

    localparam logic [TIME_W-1:0] RESET_DELAY_MS = 32'd200;
    localparam logic [TIME_W-1:0] RESET_RATE_MS  = 32'd80;
    localparam logic [TIME_W-1:0] MIN_TIME       = 32'd1;

    // Register index, taken from paddr[2]
    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_RATE  = 1'b1;

    // Control shared by every lane
    typedef struct packed {
        logic advance;       // item in the input stage moves to the result
        logic wipe;          // configuration write: disarm every deadline
        logic clear_timers;  // disarm before this item's update
        logic delay_on;      // auto-repeat enabled
    } bar_cmd_t;

    // An armed deadline of zero would read as disarmed: store 1 instead
    function automatic logic [TIME_W-1:0] arm_at(input logic [TIME_W-1:0] t);
        arm_at = (t == '0) ? MIN_TIME : t;
    endfunction

endpackage

`default_nettype wire

>>> rtl/button_auto_repeat.sv
// A word accepted into the input stage moves on to the output register when that is free.
// Throughput: one word per cycle while out_ready does not stall the output; the per-button
// deadline registers update once per word, each through one subtract and a sign-bit test.
// Reset: deadlines disarmed, delay 200 ms, rate 80 ms, both stages empty.
// pready is always high; a configuration write disarms every deadline.
// ----------------------------------------------------------------------------
// button_auto_repeat
// Typematic auto-repeat over a mask of buttons, one poll per word.
// ----------------------------------------------------------------------------
`default_nettype none

module button_auto_repeat
    import bar_pkg::*;
#(
    parameter int unsigned BUTTONS = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic      [APB_W-1:0]  prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [MASK_W-1:0] held_mask,
    input  wire logic [MASK_W-1:0] press_mask,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic              clear_timers,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [MASK_W-1:0] repeat_mask
);

    // Only the first MASK_W lanes can ever be reached by a mask bit
    localparam int unsigned LANES = (BUTTONS < MASK_W) ? BUTTONS : MASK_W;

    logic [TIME_W-1:0] delay_ms;
    logic [TIME_W-1:0] rate_ms;
    logic              wipe;

    logic              s1_valid_reg;
    logic [MASK_W-1:0] held_reg;
    logic [MASK_W-1:0] press_reg;
    logic [TIME_W-1:0] now_reg;
    logic              clear_reg;

    logic              out_valid_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;

    logic              advance;
    logic              take;
    logic [TIME_W-1:0] arm_delay;
    logic [TIME_W-1:0] arm_rate;
    logic [MASK_W-1:0] fire;
    bar_cmd_t          cmd;

    bar_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .delay_ms (delay_ms),
        .rate_ms  (rate_ms),
        .wipe     (wipe)
    );

    assign advance  = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | advance;
    assign take     = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            held_reg  <= held_mask;
            press_reg <= press_mask;
            now_reg   <= now_ms;
            clear_reg <= clear_timers;
        end
    end

    assign arm_delay = arm_at(now_reg + delay_ms);
    assign arm_rate  = arm_at(now_reg + rate_ms);

    assign cmd.advance      = advance;
    assign cmd.wipe         = wipe;
    assign cmd.clear_timers = clear_reg;
    assign cmd.delay_on     = (delay_ms != '0);

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        bar_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .held      (held_reg[i]),
            .press     (press_reg[i]),
            .now_ms    (now_reg),
            .arm_delay (arm_delay),
            .arm_rate  (arm_rate),
            .fire      (fire[i])
        );
    end

    if (LANES < MASK_W)
    begin : g_idle
        assign fire[MASK_W-1:LANES] = '0;
    end

    // Press edges always pass through
    assign mask_next = press_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg <= mask_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign repeat_mask = mask_reg;

endmodule

`default_nettype wire

>>> rtl/bar_regs.sv
// ----------------------------------------------------------------------------
// bar_regs
// APB configuration registers: repeat delay and repeat rate.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_regs
    import bar_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic      [APB_W-1:0]  prdata,
    output logic                   pready,
    output logic      [TIME_W-1:0] delay_ms,
    output logic      [TIME_W-1:0] rate_ms,
    output logic                   wipe
);

    logic [TIME_W-1:0] delay_reg;
    logic [TIME_W-1:0] rate_reg;
    logic              wr_en;
    logic              sel;

    assign pready = 1'b1;
    assign sel    = paddr[ADDR_W-1];
    assign wr_en  = psel & penable & pwrite;
    assign wipe   = wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= RESET_DELAY_MS;
            rate_reg  <= RESET_RATE_MS;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_DELAY: delay_reg <= pwdata;
                REG_RATE:  rate_reg  <= arm_at(pwdata);
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_DELAY: prdata = delay_reg;
            REG_RATE:  prdata = rate_reg;
            default:   prdata = '0;
        endcase
    end

    assign delay_ms = delay_reg;
    assign rate_ms  = rate_reg;

endmodule

`default_nettype wire

>>> rtl/bar_lane.sv
// ----------------------------------------------------------------------------
// bar_lane
// Deadline register and repeat decision for one button.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_lane
    import bar_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bar_cmd_t          cmd,
    input  wire logic              held,
    input  wire logic              press,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic [TIME_W-1:0] arm_delay,
    input  wire logic [TIME_W-1:0] arm_rate,
    output logic                   fire
);

    logic [TIME_W-1:0] dl_reg;
    logic [TIME_W-1:0] dl_next;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] diff;

    always_comb
    begin
        base    = cmd.clear_timers ? '0 : dl_reg;
        diff    = now_ms - base;
        dl_next = base;
        fire    = 1'b0;
        if (cmd.delay_on)
        begin
            if (!held)
            begin
                dl_next = '0;
            end
            else if (press)
            begin
                dl_next = arm_delay;
            end
            else if (base != '0 && !diff[TIME_W-1])
            begin
                // wrap-safe: deadline reached, re-arm one interval on
                fire    = 1'b1;
                dl_next = arm_rate;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_reg <= '0;
        end
        else if (cmd.wipe)
        begin
            dl_reg <= '0;
        end
        else if (cmd.advance)
        begin
            dl_reg <= dl_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bar_checker.sv
// ----------------------------------------------------------------------------
// bar_checker
// Port-level checks for the button auto-repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_auto_repeat_defines.svh"

module bar_checker
    import bar_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              pready,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [MASK_W-1:0] repeat_mask
);

    `BAR_ASSERT_ALWAYS(a_reset_empty, clk, (!rst_n |=> !out_valid), "output valid in reset")

    `BAR_ASSERT(a_pready, clk, rst_n, pready, "pready dropped")

    `BAR_ASSERT(a_stall_only_when_full, clk, rst_n, (!in_ready |-> (out_valid && !out_ready)), "input stalled while output free")

    `BAR_ASSERT(a_out_hold, clk, rst_n, ((out_valid && !out_ready) |=> (out_valid && $stable(repeat_mask))), "stalled output word changed")

endmodule

bind button_auto_repeat bar_checker u_bar_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .repeat_mask (repeat_mask)
);

`default_nettype wire
